// ===== rtl/cic_pkg.sv =====
// shared constants and types of the cic decimator
// no dependencies; used by every module in rtl/

package cic_pkg;

	localparam int STAGES     = 4;
	localparam int DIFF_DELAY = 2;
	localparam int ACC_WIDTH  = 52;

	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 52;
	localparam int FACTOR_W = 9;
	localparam int PHASE_W  = 8;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(8);
	localparam logic [FACTOR_W-1:0] FACTOR_MAX   = FACTOR_W'(256);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	// control that travels beside the data from cell to cell
	typedef struct packed {
		logic valid;
		logic emit;
	} cic_tag_t;

endpackage

// ===== rtl/cic_integ_cell.sv =====
// one integrator cell of the cic chain: running sum plus tag register
// depends on cic_pkg

module cic_integ_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cic_pkg::cic_tag_t in_tag,
	input  cic_pkg::acc_t     in_data,
	output cic_pkg::cic_tag_t out_tag,
	output cic_pkg::acc_t     out_data
);

	cic_pkg::acc_t     sum_q;
	cic_pkg::cic_tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			tag_q <= '0;
		end else if (en) begin
			tag_q <= in_tag;
			if (in_tag.valid) begin
				sum_q <= sum_q + in_data;
			end
		end
	end

	assign out_tag  = tag_q;
	assign out_data = sum_q;

endmodule

// ===== rtl/cic_comb_cell.sv =====
// one comb cell of the cic chain: delay line and difference register
// depends on cic_pkg

module cic_comb_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  cic_pkg::cic_tag_t in_tag,
	input  cic_pkg::acc_t     in_data,
	output cic_pkg::cic_tag_t out_tag,
	output cic_pkg::acc_t     out_data
);

	cic_pkg::acc_t     dly_q [cic_pkg::DIFF_DELAY];
	cic_pkg::acc_t     data_q;
	cic_pkg::cic_tag_t tag_q;
	logic              take;

	// only samples that close a group reach the combs
	assign take = in_tag.valid && in_tag.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cic_pkg::DIFF_DELAY; i++) begin
				dly_q[i] <= '0;
			end
			tag_q <= '0;
		end else if (en) begin
			tag_q.valid <= take;
			tag_q.emit  <= take;
			if (take) begin
				dly_q[0] <= in_data;
				for (int i = 1; i < cic_pkg::DIFF_DELAY; i++) begin
					dly_q[i] <= dly_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take) begin
			data_q <= in_data - dly_q[cic_pkg::DIFF_DELAY-1];
		end
	end

	assign out_tag  = tag_q;
	assign out_data = data_q;

endmodule

// ===== rtl/cic_out_buf.sv =====
// two-entry output buffer between the comb chain and the master port
// depends on cic_pkg

module cic_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cic_pkg::acc_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output cic_pkg::acc_t out_data
);

	cic_pkg::acc_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/cic_decimator_unit.sv =====
// cic decimator top: phase counter, integrator and comb cell chains, output buffer
// path: input beat -> STAGES integrator cells -> STAGES comb cells -> output buffer
// throughput: one input beat per cycle unless stalled; one output beat per decimation_factor inputs
// the whole cell chain advances together and holds only when the two-entry
// output buffer is full and a result sits in the last comb cell
// reset (arst_n low) clears sums, delay lines, phase and buffer; factor returns to 8

module cic_decimator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// config register: decimation_factor
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_in
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [51:0] sample_out, [55:52] zero
);

	localparam int S = cic_pkg::STAGES;

	// configuration
	logic [cic_pkg::FACTOR_W-1:0] factor_q;
	logic [cic_pkg::FACTOR_W-1:0] eff_factor;
	logic [cic_pkg::PHASE_W-1:0]  phase_q;
	logic [cic_pkg::FACTOR_W-1:0] phase_next;

	// chain wiring: index 0 is the input side of the chain
	cic_pkg::cic_tag_t integ_tag [S+1];
	cic_pkg::acc_t     integ_data [S+1];
	cic_pkg::cic_tag_t comb_tag [S+1];
	cic_pkg::acc_t     comb_data [S+1];

	logic          pipe_en;
	logic          buf_full;
	logic          in_beat;
	cic_pkg::acc_t out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= cic_pkg::FACTOR_RESET;
		end else if (cfg_wr_en) begin
			factor_q <= cfg_wr_data;
		end
	end

	// zero acts as one, anything above 256 saturates
	always_comb begin
		priority if (factor_q == '0) begin
			eff_factor = cic_pkg::FACTOR_W'(1);
		end else if (factor_q > cic_pkg::FACTOR_MAX) begin
			eff_factor = cic_pkg::FACTOR_MAX;
		end else begin
			eff_factor = factor_q;
		end
	end

	// stall only when a finished result cannot move into the buffer
	assign pipe_en  = !(comb_tag[S].valid && buf_full);
	assign s_tready = pipe_en;
	assign in_beat  = s_tvalid && s_tready;

	// phase counter marks the last sample of each group
	assign phase_next = cic_pkg::FACTOR_W'(phase_q) + cic_pkg::FACTOR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_beat) begin
			if (phase_next >= eff_factor) begin
				phase_q <= '0;
			end else begin
				phase_q <= phase_next[cic_pkg::PHASE_W-1:0];
			end
		end
	end

	assign integ_tag[0].valid = s_tvalid;
	assign integ_tag[0].emit  = (phase_next >= eff_factor);
	assign integ_data[0]      = cic_pkg::ACC_WIDTH'($signed(s_tdata));

	// integrator cells run at the full input rate
	for (genvar g = 0; g < S; g++) begin : g_integ
		cic_integ_cell u_integ (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.in_tag   (integ_tag[g]),
			.in_data  (integ_data[g]),
			.out_tag  (integ_tag[g+1]),
			.out_data (integ_data[g+1])
		);
	end

	assign comb_tag[0]  = integ_tag[S];
	assign comb_data[0] = integ_data[S];

	// comb cells only act on group-closing samples
	for (genvar g = 0; g < S; g++) begin : g_comb
		cic_comb_cell u_comb (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (pipe_en),
			.in_tag   (comb_tag[g]),
			.in_data  (comb_data[g]),
			.out_tag  (comb_tag[g+1]),
			.out_data (comb_data[g+1])
		);
	end

	cic_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pipe_en && comb_tag[S].valid),
		.push_data (comb_data[S]),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_acc)
	);

	// output wraps at ACC_WIDTH and is zero padded to whole bytes
	assign m_tdata = {4'b0000, cic_pkg::OUT_W'($unsigned(out_acc))};

	// a group-closing sample leaving the integrators must land in the first comb
	a_emit_enters_comb: assert property (@(posedge clk) disable iff (!arst_n)
		integ_tag[S].valid && integ_tag[S].emit && pipe_en |=> comb_tag[1].valid)
		else $error("group-closing sample dropped at comb entry");

	// an output beat only appears after the last comb handed over a result
	a_out_from_comb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(comb_tag[S].valid))
		else $error("output beat without a comb result");

	// a stalled result in the last comb cell is neither lost nor altered
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> comb_tag[S].valid && $stable(comb_data[S]))
		else $error("stalled comb result changed");

endmodule
